### design/tcpck_pkg.sv
// Package for the TCP checksum block: shared constants, the summary record
// passed from the byte front end to the finishing pipeline, and the one's-complement adder.
// No dependencies.
package tcpck_pkg;

    localparam int unsigned TCPCK_FIFO_DEPTH = 4;

    localparam logic [15:0] TCP_MIN_HDR    = 16'd20;
    localparam logic [3:0]  TCP_MIN_WORDS  = 4'd5;
    localparam logic [3:0]  IP_MIN_WORDS   = 4'd5;

    // Per-packet summary, written on the last byte
    typedef struct packed {
        logic [16:0] sum;       // folded running sum, up to 0x10000
        logic [7:0]  held;      // pending high byte of an odd tail
        logic        odd;       // TCP length is odd
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] plen;      // TCP length
        logic [3:0]  nib;       // data offset as used
        logic        chg;       // data offset was rewritten
        logic        bad;       // length check failed
    } t_pkt;

    // add one 16-bit word with end-around carry
    function automatic logic [16:0] f_add_word(input logic [16:0] s, input logic [15:0] w);
        logic [17:0] t;
        t = {1'b0, s} + {2'b00, w};
        return {1'b0, t[15:0]} + {15'd0, t[17:16]};
    endfunction

endpackage

### design/tcpck_front.sv
// Byte front end: tracks position in the datagram, captures IP header fields,
// fixes the data offset and sums segment words. Depends on tcpck_pkg.
module tcpck_front import tcpck_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fix_offset,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_push,
    output t_pkt       o_pkt
);

    logic [15:0] r_pos,   n_pos;
    logic [3:0]  r_hw,    n_hw;
    logic [15:0] r_tot,   n_tot;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src,   n_src;
    logic [31:0] r_dst,   n_dst;
    logic        r_frag,  n_frag;
    logic [3:0]  r_nib,   n_nib;
    logic        r_chg,   n_chg;
    logic [16:0] r_sum,   n_sum;
    logic [7:0]  r_held,  n_held;

    logic        accept;
    logic [15:0] hl4, plen, seg, n_hl4, plen_f;
    logic        in_seg;
    logic [3:0]  orig, nib;
    logic [7:0]  v;
    logic [16:0] rcvd;
    logic        bad;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_hw    = r_hw;
        n_tot   = r_tot;
        n_frag  = r_frag;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_nib   = r_nib;
        n_chg   = r_chg;
        n_sum   = r_sum;
        n_held  = r_held;
        orig    = i_byte[7:4];
        nib     = orig;
        v       = i_byte;

        // IP header capture
        case (r_pos)
            16'd0:   n_hw = i_byte[3:0];
            16'd2:   n_tot = {i_byte, r_tot[7:0]};
            16'd3:   n_tot = {r_tot[15:8], i_byte};
            16'd6:   n_frag = i_byte[5:0] != 6'd0;
            16'd7:   n_frag = r_frag || (i_byte != 8'd0);
            16'd9:   n_proto = i_byte;
            16'd12, 16'd13, 16'd14, 16'd15: n_src = {r_src[23:0], i_byte};
            16'd16, 16'd17, 16'd18, 16'd19: n_dst = {r_dst[23:0], i_byte};
            default: ;
        endcase

        // segment bytes; header fields are settled before the first one
        hl4    = {10'd0, r_hw, 2'b00};
        plen   = r_tot - hl4;
        seg    = r_pos - hl4;
        in_seg = (r_hw >= IP_MIN_WORDS) && (r_pos >= hl4) && (r_tot >= hl4) && (seg < plen);
        if (in_seg) begin
            if (seg == 16'd12) begin
                if (i_fix_offset) begin
                    if (orig < TCP_MIN_WORDS) begin
                        nib = TCP_MIN_WORDS;
                    end else if (({10'd0, orig, 2'b00} > plen) && !r_frag) begin
                        nib = plen[5:2];
                    end
                end
                n_nib = nib;
                n_chg = nib != orig;
                v     = {nib, i_byte[3:0]};
            end else if (seg == 16'd16 || seg == 16'd17) begin
                v = 8'd0;    // checksum field counts as zero
            end
            if (!seg[0]) begin
                n_held = v;
            end else begin
                n_sum = f_add_word(r_sum, {r_held, v});
            end
        end

        n_pos = (r_pos == 16'hFFFF) ? r_pos : r_pos + 16'd1;

        // length checks on the final byte
        n_hl4  = {10'd0, n_hw, 2'b00};
        rcvd   = {1'b0, r_pos} + 17'd1;
        plen_f = n_tot - n_hl4;
        bad    = (n_hw < IP_MIN_WORDS) || (rcvd < {1'b0, n_hl4}) || (n_tot < n_hl4);
        if (!bad && ((plen_f < TCP_MIN_HDR) || ({1'b0, n_tot} > rcvd))) begin
            bad = 1'b1;
        end
    end

    assign o_push      = accept && i_last;
    assign o_pkt.sum   = n_sum;
    assign o_pkt.held  = n_held;
    assign o_pkt.odd   = plen_f[0];
    assign o_pkt.src   = n_src;
    assign o_pkt.dst   = n_dst;
    assign o_pkt.proto = n_proto;
    assign o_pkt.plen  = plen_f;
    assign o_pkt.nib   = n_nib;
    assign o_pkt.chg   = n_chg;
    assign o_pkt.bad   = bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_pos   <= '0;
            r_hw    <= '0;
            r_tot   <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_frag  <= 1'b0;
            r_nib   <= '0;
            r_chg   <= 1'b0;
            r_sum   <= '0;
            r_held  <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_hw    <= n_hw;
            r_tot   <= n_tot;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_frag  <= n_frag;
            r_nib   <= n_nib;
            r_chg   <= n_chg;
            r_sum   <= n_sum;
            r_held  <= n_held;
        end
    end

endmodule

### design/tcpck_fifo.sv
// Short queue of packet summaries between the front end and the finisher.
// Depends on tcpck_pkg.
module tcpck_fifo import tcpck_pkg::*; #(
    parameter int unsigned DEPTH = TCPCK_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_pkt o_pkt
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == FULL_CNT;
    assign o_valid = r_cnt != '0;
    assign o_pkt   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

### design/tcpck_back.sv
// Finishing pipeline: adds odd-tail pad and pseudo-header words, two per stage,
// then adds the TCP length and registers the inverted sum. Depends on tcpck_pkg.
module tcpck_back import tcpck_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_pkt        i_pkt,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_checksum,
    output logic [3:0]  o_data_offset,
    output logic        o_offset_rewritten,
    output logic        o_bad_length
);

    logic        r_v1, r_v2, r_v3, r_ov;
    t_pkt        r_p1, r_p2, r_p3;
    t_pkt        n_p1, n_p2, n_p3;
    logic [15:0] r_cks;
    logic [3:0]  r_nib;
    logic        r_chg, r_bad;
    logic        adv;
    logic [16:0] s0, s1, s2, s3;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;

    always_comb begin
        s0 = i_pkt.odd ? f_add_word(i_pkt.sum, {i_pkt.held, 8'd0}) : i_pkt.sum;
        s0 = f_add_word(s0, i_pkt.src[31:16]);
        s1 = f_add_word(f_add_word(r_p1.sum, r_p1.src[15:0]), r_p1.dst[31:16]);
        s2 = f_add_word(f_add_word(r_p2.sum, r_p2.dst[15:0]), {8'd0, r_p2.proto});
        s3 = f_add_word(r_p3.sum, r_p3.plen);

        n_p1     = i_pkt;
        n_p1.sum = s0;
        n_p2     = r_p1;
        n_p2.sum = s1;
        n_p3     = r_p2;
        n_p3.sum = s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_cks <= r_p3.bad ? 16'd0 : ~s3[15:0];
            r_nib <= r_p3.bad ? 4'd0 : r_p3.nib;
            r_chg <= r_p3.bad ? 1'b0 : r_p3.chg;
            r_bad <= r_p3.bad;
        end
    end

    assign o_valid            = r_ov;
    assign o_checksum         = r_cks;
    assign o_data_offset      = r_nib;
    assign o_offset_rewritten = r_chg;
    assign o_bad_length       = r_bad;

endmodule

### design/tcp_checksum_with_offset_fix_top.sv
// Top level of the TCP checksum unit with data offset repair.
// Depends on tcpck_pkg, tcpck_front, tcpck_fifo, tcpck_back.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready | tdata = data_byte, tlast = last_byte
//  m       | out | o_m_tvalid / i_m_tready | tdata = checksum, data_offset,
//          |     |                         |         offset_rewritten, bad_length
//  cfg     | in  | i_cfg_valid/o_cfg_ready | fix_offset
//
// One datagram byte is taken per cycle while the summary queue is not full.
// After the last byte's transaction the summary enters the queue, three
// stages then add the odd-tail pad and the pseudo-header two words at a time,
// and the output register adds the TCP length and inverts the sum.
// Reset is synchronous and active low; it clears the front end, the stage
// valid flags, the queue and fix_offset. A stalled output holds the finishing
// pipeline; the front keeps taking bytes until the summary queue is full, which
// only happens when that many packets have ended while the output stays blocked.
module tcp_checksum_with_offset_fix_top import tcpck_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = TCPCK_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tlast,    // last_byte
    // stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,    // [15:0] checksum, [19:16] data_offset,
                                      // [20] offset_rewritten, [21] bad_length, [23:22] zero
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data    // fix_offset
);

    logic        r_fix_offset;
    logic        q_full, q_valid, q_pop, push;
    t_pkt        push_pkt, head_pkt;
    logic [15:0] checksum;
    logic [3:0]  data_offset;
    logic        offset_rewritten, bad_length;

    // config register is always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_offset <= 1'b0;
        end else if (i_cfg_valid) begin
            r_fix_offset <= i_cfg_data;
        end
    end

    tcpck_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fix_offset (r_fix_offset),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_pkt        (push_pkt)
    );

    tcpck_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_pkt   (head_pkt)
    );

    tcpck_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (q_valid),
        .o_ready            (q_pop),
        .i_pkt              (head_pkt),
        .o_valid            (o_m_tvalid),
        .i_ready            (i_m_tready),
        .o_checksum         (checksum),
        .o_data_offset      (data_offset),
        .o_offset_rewritten (offset_rewritten),
        .o_bad_length       (bad_length)
    );

    assign o_m_tdata = {2'b00, bad_length, offset_rewritten, data_offset, checksum};

endmodule
